// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, switched off during reset
`define ASSERT_PROP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `ASSERT_PROP(label, clk, rst, 1'b1, cond, msg)

`endif

// File: hdl/owtr_pkg.sv
// ----------------------------------------------------------------------------
// One-wire temperature reader package
// Payload types, line drive codes, request codes, bus commands and fixed bus timings.
// ----------------------------------------------------------------------------
package owtr_pkg;

   // Request opcodes
   localparam logic [1:0] OP_NONE      = 2'd0;
   localparam logic [1:0] OP_CONVERT   = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;
   localparam logic [1:0] OP_CONV_READ = 2'd3;

   // Line drive codes
   localparam logic [1:0] DRV_REL  = 2'd0;
   localparam logic [1:0] DRV_LOW  = 2'd1;
   localparam logic [1:0] DRV_HIGH = 2'd2;

   // ROM and function commands
   localparam logic [7:0] CMD_MATCH_ROM   = 8'h55;
   localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
   localparam logic [7:0] CMD_CONVERT     = 8'h44;
   localparam logic [7:0] CMD_READ_SCRPAD = 8'hBE;

   // Fixed bus timings in microseconds
   localparam int RESET_HIGH_US  = 15;
   localparam int READ_LOW_US    = 2;
   localparam int READ_SAMPLE_AT = 14;
   localparam int READ_TAIL_US   = 50;
   localparam int WRITE_SHORT_US = 2;
   localparam int READ_END_US    = READ_SAMPLE_AT + READ_TAIL_US - 1;

   // Bytes sent: command, eight ID bytes, function command (skip ROM: two bytes)
   localparam logic [3:0] LAST_IDX_MATCH = 4'd9;
   localparam logic [3:0] LAST_IDX_SKIP  = 4'd1;

   typedef struct packed {
      logic        line_level;
      logic [1:0]  opcode;
      logic [63:0] rom_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         line_drive;
      logic               busy_res;
      logic               done_res;
      logic               presence_missing;
      logic               temperature_valid;
      logic signed [15:0] temperature;
   } rsp_payload_type;

endpackage

// File: hdl/one_wire_temperature_reader.sv
// ----------------------------------------------------------------------------
// One-wire temperature reader
// 1-Wire bus master: reset, presence check, ROM addressing, convert and
// scratchpad read, with conversion of the reading to tenths of a degree.
// ----------------------------------------------------------------------------
// Each request transaction is one microsecond of bus time: it carries the
// sampled line level and, while the master is idle, a request opcode and
// device ID; the response transaction gives the line drive for that
// microsecond plus status and, on the final tick of a read, the temperature.
// Every tick is handled by the combinational bus sequencer between the
// request handshake and a registered response stage, so a new tick is taken
// every cycle while the response side keeps up; the only stall is a held
// response that has not yet been taken.
module one_wire_temperature_reader
   import owtr_pkg::*;
#(
   parameter int RESET_LOW_US          = 750,
   parameter int PRESENCE_LOW_WAIT_US  = 200,
   parameter int PRESENCE_HIGH_WAIT_US = 240,
   parameter int SLOT_US               = 60
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

`include "assert_macros.svh"

   localparam int WRITE_END_US = SLOT_US + WRITE_SHORT_US - 1;
   localparam int MAX_A  = (RESET_LOW_US > PRESENCE_LOW_WAIT_US) ?
                           RESET_LOW_US : PRESENCE_LOW_WAIT_US;
   localparam int MAX_B  = (PRESENCE_HIGH_WAIT_US > WRITE_END_US) ?
                           PRESENCE_HIGH_WAIT_US : WRITE_END_US;
   localparam int MAX_C  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int MAX_US = (MAX_C > READ_END_US) ? MAX_C : READ_END_US;
   localparam int TW     = $clog2(MAX_US + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_HIGH,
      PH_PRES_LOW,
      PH_PRES_HIGH,
      PH_WRITE,
      PH_READ
   } phase_type;

   phase_type       phase_ff, phase_in, phase_cur;
   logic [TW-1:0]   timer_ff, timer_in, timer_cur, timer_inc;
   logic [2:0]      bit_index_ff, bit_index_in;
   logic [3:0]      byte_index_ff, byte_index_in;
   logic [7:0]      shift_byte_ff, shift_byte_in;
   logic [63:0]     rom_id_ff, rom_id_in;
   logic [1:0]      opcode_ff, opcode_in;
   logic [7:0]      low_byte_ff, low_byte_in;
   logic            pres_fail_ff, pres_fail_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_in;
   logic            req_accept;
   logic            start;
   logic [7:0]      wr_byte;
   logic            wr_bit;
   logic [3:0]      last_idx;

   // Byte on the wire at a given write position
   function automatic logic [7:0] write_byte(input logic [3:0] idx,
                                             input logic [63:0] rom,
                                             input logic [1:0] op);
      logic [7:0] cmd;
      logic [7:0] res;
      cmd = (op == OP_READ) ? CMD_READ_SCRPAD : CMD_CONVERT;
      res = cmd;
      if (rom != '0) begin
         case (idx)
            4'd0:    res = CMD_MATCH_ROM;
            4'd1:    res = rom[7:0];
            4'd2:    res = rom[15:8];
            4'd3:    res = rom[23:16];
            4'd4:    res = rom[31:24];
            4'd5:    res = rom[39:32];
            4'd6:    res = rom[47:40];
            4'd7:    res = rom[55:48];
            4'd8:    res = rom[63:56];
            default: res = cmd;
         endcase
      end else if (idx == 4'd0) begin
         res = CMD_SKIP_ROM;
      end
      return res;
   endfunction

   // Scratchpad bytes to tenths of a degree: magnitude * 5/8, then signed
   function automatic logic signed [15:0] to_tenths(input logic [7:0] th_raw,
                                                    input logic [7:0] tl_raw);
      logic        neg;
      logic [7:0]  th;
      logic [7:0]  tl;
      logic [14:0] mag;
      logic [17:0] prod;
      logic [15:0] v;
      neg  = th_raw > 8'd7;
      th   = neg ? ~th_raw : th_raw;
      tl   = neg ? ~tl_raw : tl_raw;
      mag  = th[7] ? 15'h7FFF : {th[6:0], tl};
      prod = {3'b000, mag} + {1'b0, mag, 2'b00};
      v    = {1'b0, prod[17:3]};
      return neg ? -$signed(v) : $signed(v);
   endfunction

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Request capture while idle
   assign start     = (phase_ff == PH_IDLE) && (req_data.opcode != OP_NONE);
   assign phase_cur = start ? PH_RST_LOW : phase_ff;
   assign timer_cur = start ? '0 : timer_ff;
   assign timer_inc = timer_cur + 1'b1;
   // writes never overlap a fresh request, so the held ID and opcode serve
   assign wr_byte   = write_byte(byte_index_ff, rom_id_ff, opcode_ff);
   assign wr_bit    = wr_byte[bit_index_ff];
   assign last_idx  = (rom_id_ff != '0) ? LAST_IDX_MATCH : LAST_IDX_SKIP;

   // Bus sequencer for one microsecond tick
   always_comb begin
      phase_in      = phase_cur;
      timer_in      = timer_cur;
      bit_index_in  = bit_index_ff;
      byte_index_in = byte_index_ff;
      shift_byte_in = shift_byte_ff;
      rom_id_in     = start ? req_data.rom_id : rom_id_ff;
      opcode_in     = start ? req_data.opcode : opcode_ff;
      low_byte_in   = low_byte_ff;
      pres_fail_in  = start ? 1'b0 : pres_fail_ff;
      rsp_in        = '0;
      rsp_in.line_drive = DRV_REL;
      rsp_in.busy_res   = 1'b1;

      unique case (phase_cur)
         PH_RST_LOW: begin
            rsp_in.line_drive = DRV_LOW;
            timer_in = timer_inc;
            if (timer_inc >= TW'(RESET_LOW_US)) begin
               phase_in = PH_RST_HIGH;
               timer_in = '0;
            end
         end
         PH_RST_HIGH: begin
            rsp_in.line_drive = DRV_HIGH;
            timer_in = timer_inc;
            if (timer_inc >= TW'(RESET_HIGH_US)) begin
               phase_in = PH_PRES_LOW;
               timer_in = '0;
            end
         end
         PH_PRES_LOW: begin
            if (!req_data.line_level) begin
               phase_in = PH_PRES_HIGH;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
               if (timer_inc >= TW'(PRESENCE_LOW_WAIT_US)) begin
                  pres_fail_in  = 1'b1;
                  phase_in      = PH_WRITE;
                  timer_in      = '0;
                  bit_index_in  = '0;
                  byte_index_in = '0;
               end
            end
         end
         PH_PRES_HIGH: begin
            if (req_data.line_level) begin
               phase_in      = PH_WRITE;
               timer_in      = '0;
               bit_index_in  = '0;
               byte_index_in = '0;
            end else begin
               timer_in = timer_inc;
               if (timer_inc >= TW'(PRESENCE_HIGH_WAIT_US)) begin
                  pres_fail_in  = 1'b1;
                  phase_in      = PH_WRITE;
                  timer_in      = '0;
                  bit_index_in  = '0;
                  byte_index_in = '0;
               end
            end
         end
         PH_WRITE: begin
            // Write 1: short low then high; write 0: long low then high
            if (wr_bit) begin
               rsp_in.line_drive = (timer_cur < TW'(WRITE_SHORT_US)) ? DRV_LOW : DRV_HIGH;
            end else begin
               rsp_in.line_drive = (timer_cur < TW'(SLOT_US)) ? DRV_LOW : DRV_HIGH;
            end
            if (timer_cur >= TW'(WRITE_END_US)) begin
               timer_in     = '0;
               bit_index_in = bit_index_ff + 1'b1;
               if (bit_index_ff == 3'd7) begin
                  byte_index_in = byte_index_ff + 1'b1;
                  if (byte_index_ff == last_idx) begin
                     byte_index_in = '0;
                     case (opcode_in)
                        OP_CONV_READ: begin
                           opcode_in = OP_READ;
                           phase_in  = PH_RST_LOW;
                        end
                        OP_READ: begin
                           phase_in      = PH_READ;
                           shift_byte_in = '0;
                        end
                        default: begin
                           phase_in        = PH_IDLE;
                           rsp_in.done_res = 1'b1;
                        end
                     endcase
                  end
               end
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_READ: begin
            rsp_in.line_drive = (timer_cur < TW'(READ_LOW_US)) ? DRV_LOW : DRV_REL;
            if (timer_cur == TW'(READ_SAMPLE_AT)) begin
               shift_byte_in = {req_data.line_level, shift_byte_ff[7:1]};
            end
            if (timer_cur >= TW'(READ_END_US)) begin
               timer_in     = '0;
               bit_index_in = bit_index_ff + 1'b1;
               if (bit_index_ff == 3'd7) begin
                  if (byte_index_ff == 4'd0) begin
                     low_byte_in   = shift_byte_ff;
                     byte_index_in = 4'd1;
                     shift_byte_in = '0;
                  end else begin
                     byte_index_in            = '0;
                     phase_in                 = PH_IDLE;
                     rsp_in.done_res          = 1'b1;
                     rsp_in.temperature_valid = 1'b1;
                     rsp_in.temperature       = to_tenths(shift_byte_ff, low_byte_ff);
                  end
               end
            end else begin
               timer_in = timer_inc;
            end
         end
         default: begin
            rsp_in.busy_res = 1'b0;
         end
      endcase

      rsp_in.presence_missing = pres_fail_in;
   end

   // Sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         timer_ff      <= '0;
         bit_index_ff  <= '0;
         byte_index_ff <= '0;
         shift_byte_ff <= '0;
         rom_id_ff     <= '0;
         opcode_ff     <= OP_NONE;
         low_byte_ff   <= '0;
         pres_fail_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff      <= phase_in;
            timer_ff      <= timer_in;
            bit_index_ff  <= bit_index_in;
            byte_index_ff <= byte_index_in;
            shift_byte_ff <= shift_byte_in;
            rom_id_ff     <= rom_id_in;
            opcode_ff     <= opcode_in;
            low_byte_ff   <= low_byte_in;
            pres_fail_ff  <= pres_fail_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Checks
   `ASSERT_PROP(a_idle_timer_clear, clock, reset, phase_ff == PH_IDLE, timer_ff == '0, "timer not cleared while idle")
   `ASSERT_PROP(a_done_leaves_idle, clock, reset, rsp_valid_ff && rsp_data_ff.done_res, phase_ff == PH_IDLE, "finished sequence not idle")
   `ASSERT_PROP(a_read_opcode, clock, reset, phase_ff == PH_READ, opcode_ff == OP_READ, "read slots without read request")
   `ASSERT_ALWAYS(a_byte_index_range, clock, reset, byte_index_ff <= LAST_IDX_MATCH, "byte index out of range")

endmodule
